### design/sdr_pkg.sv
// Package for the self-calibrating dial reader.
// Holds operation codes, sequencer states, command and status structs and shared constants.
// No dependencies.
package sdr_pkg;

   // Operation codes carried by a request beat.
   typedef enum logic [1:0] {
      OP_SAMPLE      = 2'd0,
      OP_READ_POS    = 2'd1,
      OP_SET_LIMITS  = 2'd2,
      OP_READ_LIMITS = 2'd3
   } sdr_op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_WIDEN,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_CLAMP,
      ST_MUL,
      ST_DONE
   } sdr_state_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic capture;
      logic update;
      logic widen;
      logic div_init;
      logic div_step;
      logic div_last;
      logic clamp;
      logic mul;
      logic load_out;
   } sdr_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic bad;
      logic need_div;
      logic span_pos;
      logic out_free;
   } sdr_status_type;

   // Full scale of a 16-bit value.
   localparam int MAX_16 = 65535;
   // Dividend of the span reciprocal.
   localparam longint unsigned RECIP_NUM = 64'h0000_0000_ffff_ffff;
   // Quotient bits, one produced per divider step.
   localparam int QUO_BITS = 32;
   localparam int CNT_W = $clog2(QUO_BITS);

endpackage

### design/sdr_if.sv
// Handshake channels of the dial reader: request and response.
// Depends on nothing; payload widths are fixed by the item formats.
interface sdr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [3:0]  dial;
   logic [11:0] sample;
   logic [15:0] limit_low;
   logic [15:0] limit_high;

   modport source (output valid, operation, dial, sample, limit_low, limit_high,
                   input ready);
   modport sink (input valid, operation, dial, sample, limit_low, limit_high,
                 output ready);
endinterface

interface sdr_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  which_dial;
   logic [15:0] position;
   logic [15:0] low_limit;
   logic [15:0] high_limit;
   logic        bad_index;

   modport source (output valid, which_dial, position, low_limit, high_limit, bad_index,
                   input ready);
   modport sink (input valid, which_dial, position, low_limit, high_limit, bad_index,
                 output ready);
endinterface

### design/sdr_ctrl.sv
// Sequencer of the dial reader: steps one request through update, widen, divide and scale.
// Depends on sdr_pkg for states, commands and status.
module sdr_ctrl import sdr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  sdr_status_type status,
   output sdr_cmd_type    cmd
);

   sdr_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.bad ? ST_DONE : ST_WIDEN;
         end
         ST_WIDEN: begin
            cmd.widen = 1'b1;
            state_in  = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            // A zero or negative span is settled here without dividing.
            cnt_in = '0;
            if (!status.need_div) begin
               state_in = ST_CLAMP;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = status.span_pos ? ST_DIV_STEP : ST_CLAMP;
            end
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_BITS - 1)) begin
               cmd.div_last = 1'b1;
               state_in     = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/sdr_datapath.sv
// Datapath of the dial reader: per-dial state, restoring divider, scaling multiplier
// and the response register. Depends on sdr_pkg; driven by sdr_ctrl commands.
module sdr_datapath import sdr_pkg::*; #(
   parameter int DIALS       = 2,
   parameter int DEADZONE    = 32,
   parameter int SAMPLE_BITS = 12
) (
   input  logic           clock,
   input  logic           reset,
   input  sdr_cmd_type    cmd,
   output sdr_status_type status,
   input  logic [1:0]     req_operation,
   input  logic [3:0]     req_dial,
   input  logic [11:0]    req_sample,
   input  logic [15:0]    req_limit_low,
   input  logic [15:0]    req_limit_high,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [3:0]     rsp_which_dial,
   output logic [15:0]    rsp_position,
   output logic [15:0]    rsp_low_limit,
   output logic [15:0]    rsp_high_limit,
   output logic           rsp_bad_index
);

   localparam int          IDX_W       = (DIALS > 1) ? $clog2(DIALS) : 1;
   localparam logic [16:0] DZ_17       = 17'(DEADZONE);
   localparam logic [15:0] MIN_RESET   = 16'(DEADZONE);
   localparam logic [15:0] MAX_RESET   = 16'(MAX_16 - DEADZONE);
   localparam logic [31:0] RECIP_RESET = 32'(RECIP_NUM / (MAX_16 - 2 * DEADZONE));
   localparam logic [IDX_W:0] DIALS_W  = (IDX_W + 1)'(DIALS);

   // Per-dial state.
   logic [15:0] sum_ff   [DIALS], sum_in   [DIALS];
   logic [15:0] min_ff   [DIALS], min_in   [DIALS];
   logic [15:0] max_ff   [DIALS], max_in   [DIALS];
   logic [31:0] recip_ff [DIALS], recip_in [DIALS];
   logic [IDX_W-1:0] ptr_ff, ptr_in;

   // Captured request.
   sdr_op_type       op_ff, op_in;
   logic [3:0]       dial_ff, dial_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             bad_ff, bad_in;
   logic [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic [15:0]      liml_ff, liml_in;
   logic [15:0]      limh_ff, limh_in;
   logic             need_div_ff, need_div_in;

   // Divider, clamp and scale.
   logic [16:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] span_ff, span_in;
   logic [15:0] vrel_ff, vrel_in;
   logic        vzero_ff, vzero_in;
   logic [15:0] pos_ff, pos_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  out_dial_ff, out_dial_in;
   logic [15:0] out_pos_ff, out_pos_in;
   logic [15:0] out_lo_ff, out_lo_in;
   logic [15:0] out_hi_ff, out_hi_in;
   logic        out_bad_ff, out_bad_in;

   // Working values.
   logic [15:0] sum_cur, min_cur, max_cur;
   logic [31:0] recip_cur;
   logic [IDX_W:0] ptr_plus;
   logic        req_bad;
   logic [16:0] acc_17, mn_17, acc_pd, acc_md, max_pd, hi_17;
   logic [15:0] acc_new, mn_new, mx_new, v_clamp, lo_rep, hi_rep;
   logic        lo_wide, hi_wide;
   logic [16:0] rem_sh;
   logic        q_bit;
   logic [31:0] prod;

   assign sum_cur   = sum_ff[idx_ff];
   assign min_cur   = min_ff[idx_ff];
   assign max_cur   = max_ff[idx_ff];
   assign recip_cur = recip_ff[idx_ff];

   always_comb begin
      sum_in      = sum_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      recip_in    = recip_ff;
      ptr_in      = ptr_ff;
      op_in       = op_ff;
      dial_in     = dial_ff;
      idx_in      = idx_ff;
      bad_in      = bad_ff;
      smp_in      = smp_ff;
      liml_in     = liml_ff;
      limh_in     = limh_ff;
      need_div_in = need_div_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      span_in     = span_ff;
      vrel_in     = vrel_ff;
      vzero_in    = vzero_ff;
      pos_in      = pos_ff;
      out_dial_in = out_dial_ff;
      out_pos_in  = out_pos_ff;
      out_lo_in   = out_lo_ff;
      out_hi_in   = out_hi_ff;
      out_bad_in  = out_bad_ff;

      // Request capture; a sample goes to the dial under the poll pointer.
      ptr_plus = {1'b0, ptr_ff} + 1'b1;
      req_bad  = ({1'b0, req_dial} >= 5'(DIALS));
      if (cmd.capture) begin
         op_in   = sdr_op_type'(req_operation);
         smp_in  = req_sample[SAMPLE_BITS-1:0];
         liml_in = req_limit_low;
         limh_in = req_limit_high;
         if (sdr_op_type'(req_operation) == OP_SAMPLE) begin
            idx_in  = ptr_ff;
            dial_in = 4'(ptr_ff);
            bad_in  = 1'b0;
            ptr_in  = (ptr_plus >= DIALS_W) ? '0 : ptr_plus[IDX_W-1:0];
         end else begin
            idx_in  = req_bad ? '0 : req_dial[IDX_W-1:0];
            dial_in = req_dial;
            bad_in  = req_bad;
         end
      end

      // Leaky sum update, or new limits with the deadzone applied.
      acc_17  = {1'b0, sum_cur} - {5'b0, sum_cur[15:4]} + 17'(smp_ff);
      acc_new = acc_17[16] ? 16'hffff : acc_17[15:0];
      mn_17   = {1'b0, liml_ff} + DZ_17;
      mn_new  = mn_17[16] ? 16'hffff : mn_17[15:0];
      mx_new  = ({1'b0, limh_ff} < DZ_17) ? 16'h0000 : 16'({1'b0, limh_ff} - DZ_17);
      if (cmd.update && !bad_ff) begin
         if (op_ff == OP_SAMPLE) begin
            sum_in[idx_ff] = acc_new;
         end
         if (op_ff == OP_SET_LIMITS) begin
            min_in[idx_ff] = mn_new;
            max_in[idx_ff] = mx_new;
         end
      end

      // Widening of the limits toward the sum, in full precision.
      acc_pd  = {1'b0, sum_cur} + DZ_17;
      acc_md  = {1'b0, sum_cur} - DZ_17;
      max_pd  = {1'b0, max_cur} + DZ_17;
      lo_wide = ({1'b0, min_cur} > acc_pd);
      hi_wide = (max_pd < {1'b0, sum_cur});
      if (cmd.widen) begin
         need_div_in = 1'b0;
         if (op_ff == OP_SAMPLE || op_ff == OP_SET_LIMITS) begin
            if (lo_wide) begin
               min_in[idx_ff] = acc_pd[15:0];
            end
            if (hi_wide) begin
               max_in[idx_ff] = acc_md[15:0];
            end
            need_div_in = (op_ff == OP_SET_LIMITS) || lo_wide || hi_wide;
         end
      end

      // Restoring divider of all ones by the span, one quotient bit per step.
      rem_sh = {rem_ff[15:0], 1'b1};
      q_bit  = (rem_sh >= {1'b0, span_ff});
      if (cmd.div_init) begin
         rem_in  = '0;
         quo_in  = '0;
         span_in = max_cur - min_cur;
         if (!status.span_pos) begin
            recip_in[idx_ff] = '1;
         end
      end
      if (cmd.div_step) begin
         rem_in = q_bit ? (rem_sh - {1'b0, span_ff}) : rem_sh;
         quo_in = {quo_ff[30:0], q_bit};
         if (cmd.div_last) begin
            recip_in[idx_ff] = {quo_ff[30:0], q_bit};
         end
      end

      // Clamp of the sum into the limits.
      v_clamp = (sum_cur > max_cur) ? max_cur : sum_cur;
      if (cmd.clamp) begin
         vzero_in = (v_clamp < min_cur);
         vrel_in  = v_clamp - min_cur;
      end

      // Scaling by the reciprocal; the position is bits 31:16 of the product.
      prod = 32'(vrel_ff) * recip_cur;
      if (cmd.mul) begin
         pos_in = vzero_ff ? 16'h0000 : prod[31:16];
      end

      // Reported limits with the deadzone stripped and saturated.
      lo_rep = ({1'b0, min_cur} >= DZ_17) ? 16'({1'b0, min_cur} - DZ_17) : 16'h0000;
      hi_17  = {1'b0, max_cur} + DZ_17;
      hi_rep = hi_17[16] ? 16'hffff : hi_17[15:0];

      // Response register; it frees as soon as the beat is taken.
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         out_dial_in  = dial_ff;
         out_bad_in   = bad_ff;
         out_pos_in   = bad_ff ? 16'h0000 : pos_ff;
         out_lo_in    = bad_ff ? 16'h0000 : lo_rep;
         out_hi_in    = bad_ff ? 16'h0000 : hi_rep;
      end
   end

   // State registers with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIALS; i++) begin
            sum_ff[i]   <= '0;
            min_ff[i]   <= MIN_RESET;
            max_ff[i]   <= MAX_RESET;
            recip_ff[i] <= RECIP_RESET;
         end
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         recip_ff     <= recip_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      dial_ff     <= dial_in;
      idx_ff      <= idx_in;
      bad_ff      <= bad_in;
      smp_ff      <= smp_in;
      liml_ff     <= liml_in;
      limh_ff     <= limh_in;
      need_div_ff <= need_div_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      span_ff     <= span_in;
      vrel_ff     <= vrel_in;
      vzero_ff    <= vzero_in;
      pos_ff      <= pos_in;
      out_dial_ff <= out_dial_in;
      out_pos_ff  <= out_pos_in;
      out_lo_ff   <= out_lo_in;
      out_hi_ff   <= out_hi_in;
      out_bad_ff  <= out_bad_in;
   end

   // Status to the sequencer.
   assign status.bad      = bad_ff;
   assign status.need_div = need_div_ff;
   assign status.span_pos = (max_cur > min_cur);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_which_dial = out_dial_ff;
   assign rsp_position   = out_pos_ff;
   assign rsp_low_limit  = out_lo_ff;
   assign rsp_high_limit = out_hi_ff;
   assign rsp_bad_index  = out_bad_ff;

endmodule

### design/self_calibrating_dial_reader_core.sv
// Top level of the self-calibrating dial reader: sequencer plus datapath.
// Depends on sdr_pkg, sdr_if, sdr_ctrl and sdr_datapath.
//
//   Channel  Direction  Beat carries
//   req      in         operation, dial, sample, limit_low, limit_high
//   rsp      out        which_dial, position, low_limit, high_limit, bad_index
//
// One request is worked at a time; req.ready is high only while the sequencer idles.
// From accept to response load the sequencer steps through update, widen, divide, clamp,
// multiply and done; the span reciprocal comes from a restoring divider, one bit a cycle, run
// only for a limit set or move with a positive span. A bad index goes from update to done.
// A stalled rsp does not block the next accept; only a second finished response waits.
// Reset is synchronous and loads every dial's state at once; no clearing pass is needed.
module self_calibrating_dial_reader_core import sdr_pkg::*; #(
   parameter int DIALS       = 2,
   parameter int DEADZONE    = 32,
   parameter int SAMPLE_BITS = 12
) (
   input logic       clock,
   input logic       reset,
   sdr_req_if.sink   req,
   sdr_rsp_if.source rsp
);

   sdr_cmd_type    cmd;
   sdr_status_type status;

   // Sequencer.
   sdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   sdr_datapath #(
      .DIALS       (DIALS),
      .DEADZONE    (DEADZONE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req.operation),
      .req_dial       (req.dial),
      .req_sample     (req.sample),
      .req_limit_low  (req.limit_low),
      .req_limit_high (req.limit_high),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_which_dial (rsp.which_dial),
      .rsp_position   (rsp.position),
      .rsp_low_limit  (rsp.low_limit),
      .rsp_high_limit (rsp.high_limit),
      .rsp_bad_index  (rsp.bad_index)
   );

endmodule

### dv/tb.sv
// Self-checking testbench for self_calibrating_dial_reader_core: directed corners, then random
// calibration sweeps, checked beat by beat against an in-bench model of the dial state.
// Depends on sdr_pkg, sdr_if and the core RTL.
module tb;
   import sdr_pkg::*;

   localparam int N_DIALS     = 2;
   localparam int DZ          = 32;
   localparam int SBITS       = 12;
   localparam int SAMPLE_MASK = (1 << SBITS) - 1;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 60;
   localparam int CYCLE_LIMIT = 400000;

   // One response beat as the block should deliver it.
   typedef struct {
      logic [3:0]  which_dial;
      logic [15:0] position;
      logic [15:0] low_limit;
      logic [15:0] high_limit;
      logic        bad_index;
   } dial_result_type;

   logic clock;
   logic reset;

   sdr_req_if req_ch ();
   sdr_rsp_if rsp_ch ();

   self_calibrating_dial_reader_core #(
      .DIALS       (N_DIALS),
      .DEADZONE    (DZ),
      .SAMPLE_BITS (SBITS)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Tracked dial state.
   logic [15:0] sum_q   [N_DIALS];
   logic [15:0] min_q   [N_DIALS];
   logic [15:0] max_q   [N_DIALS];
   logic [31:0] recip_q [N_DIALS];
   int unsigned poll_idx;

   dial_result_type pending_results [$];

   int unsigned beats_sent;
   int unsigned results_checked;
   int unsigned mismatches;
   int unsigned cycle_count;
   bit          send_idle_on;
   bit          rsp_stall_on;
   bit          hold_request;

   // Clock with a period of 2.
   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Reciprocal of the span; an empty or negative span saturates.
   function automatic logic [31:0] span_recip(int d);
      if (max_q[d] <= min_q[d]) return 32'hffff_ffff;
      return 32'hffff_ffff / 32'(max_q[d] - min_q[d]);
   endfunction

   // Widen min or max when the sum leaves them by more than the deadzone.
   function automatic void follow_sum(int d);
      int acc;
      int mn;
      int mx;
      acc = int'(sum_q[d]);
      mn  = int'(min_q[d]);
      mx  = int'(max_q[d]);
      if (mn > acc + DZ) begin
         min_q[d]   = 16'(acc + DZ);
         recip_q[d] = span_recip(d);
      end
      if (mx < acc - DZ) begin
         max_q[d]   = 16'(acc - DZ);
         recip_q[d] = span_recip(d);
      end
   endfunction

   // Clamp the sum into min..max, then scale to the full 16-bit range.
   function automatic logic [15:0] dial_position(int d);
      logic [15:0] v;
      logic [63:0] prod;
      v = sum_q[d];
      if (v > max_q[d]) v = max_q[d];
      if (v < min_q[d]) return 16'd0;
      prod = 64'(v - min_q[d]) * 64'(recip_q[d]);
      return prod[31:16];
   endfunction

   function automatic dial_result_type dial_report(int d);
      dial_result_type r;
      r.which_dial = 4'(d);
      r.position   = dial_position(d);
      r.low_limit  = 16'(clamp_int(int'(min_q[d]) - DZ, 0, MAX_16));
      r.high_limit = 16'(clamp_int(int'(max_q[d]) + DZ, 0, MAX_16));
      r.bad_index  = 1'b0;
      return r;
   endfunction

   function automatic void reset_dial_state();
      for (int d = 0; d < N_DIALS; d++) begin
         sum_q[d]   = '0;
         min_q[d]   = 16'(DZ);
         max_q[d]   = 16'(MAX_16 - DZ);
         recip_q[d] = span_recip(d);
      end
      poll_idx = 0;
   endfunction

   // Applies one request to the tracked state and returns the response it must produce.
   function automatic dial_result_type predict_dial_result(sdr_op_type op, logic [3:0] dial,
                                                           logic [11:0] sample,
                                                           logic [15:0] lim_lo,
                                                           logic [15:0] lim_hi);
      dial_result_type r;
      int p;
      int acc;
      if (op == OP_SAMPLE) begin
         p   = (poll_idx >= N_DIALS) ? 0 : int'(poll_idx);
         acc = int'(sum_q[p]);
         acc = acc - (acc >> 4) + (int'(sample) & SAMPLE_MASK);
         sum_q[p] = 16'(clamp_int(acc, 0, MAX_16));
         follow_sum(p);
         r = dial_report(p);
         poll_idx = (p + 1 >= N_DIALS) ? 0 : p + 1;
         return r;
      end
      if (dial >= N_DIALS) begin
         r.which_dial = dial;
         r.position   = '0;
         r.low_limit  = '0;
         r.high_limit = '0;
         r.bad_index  = 1'b1;
         return r;
      end
      if (op == OP_SET_LIMITS) begin
         min_q[dial]   = 16'(clamp_int(int'(lim_lo) + DZ, 0, MAX_16));
         max_q[dial]   = 16'(clamp_int(int'(lim_hi) - DZ, 0, MAX_16));
         recip_q[dial] = span_recip(dial);
         follow_sum(dial);
      end
      return dial_report(dial);
   endfunction

   // Offers one request beat, with an optional idle burst ahead of it; called at a falling edge.
   task automatic send_beat(sdr_op_type op, logic [3:0] dial, logic [11:0] sample,
                            logic [15:0] lim_lo, logic [15:0] lim_hi);
      if (send_idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.operation  = op;
      req_ch.dial       = dial;
      req_ch.sample     = sample;
      req_ch.limit_low  = lim_lo;
      req_ch.limit_high = lim_hi;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(predict_dial_result(op, dial, sample, lim_lo, lim_hi));
      beats_sent++;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic wait_for_results();
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         mismatches++;
      end
   endtask

   // Response checker: every accepted beat against the oldest prediction.
   always @(posedge clock) begin
      dial_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("response beat for dial %0d with no request outstanding", rsp_ch.which_dial);
            mismatches++;
         end else begin
            exp_r = pending_results.pop_front();
            check_field("which_dial", 32'(exp_r.which_dial), 32'(rsp_ch.which_dial));
            check_field("position", 32'(exp_r.position), 32'(rsp_ch.position));
            check_field("low_limit", 32'(exp_r.low_limit), 32'(rsp_ch.low_limit));
            check_field("high_limit", 32'(exp_r.high_limit), 32'(rsp_ch.high_limit));
            check_field("bad_index", 32'(exp_r.bad_index), 32'(rsp_ch.bad_index));
            results_checked++;
         end
      end
   end

   // Response ready: random stall bursts, plus one long hold on request.
   initial begin
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ch.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
         end else if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Full-scale samples drive both sums up, then back down.
   task automatic test_sample_extremes();
      send_beat(OP_SAMPLE, 4'd15, 12'hfff, 16'hffff, 16'h0000);
      send_beat(OP_SAMPLE, 4'd0, 12'hfff, 16'h0000, 16'hffff);
      send_beat(OP_SAMPLE, 4'd7, 12'h000, 16'h5555, 16'haaaa);
      send_beat(OP_SAMPLE, 4'd8, 12'h000, 16'haaaa, 16'h5555);
   endtask

   task automatic test_reads();
      for (int d = 0; d < N_DIALS; d++) begin
         send_beat(OP_READ_POS, 4'(d), 12'(d), 16'hffff, 16'hffff);
         send_beat(OP_READ_LIMITS, 4'(d), 12'hfff, 16'h0000, 16'h0000);
      end
   endtask

   // Dial indexes at and beyond the dial count, for every indexed operation.
   task automatic test_bad_index();
      send_beat(OP_READ_POS, 4'(N_DIALS), 12'h0ff, 16'h1234, 16'h4321);
      send_beat(OP_SET_LIMITS, 4'd15, 12'h800, 16'hffff, 16'h0000);
      send_beat(OP_READ_LIMITS, 4'd8, 12'h000, 16'h0000, 16'hffff);
   endtask

   // Saturating, widest, zero-span and inverted limit settings.
   task automatic test_limit_corners();
      int s;
      send_beat(OP_SET_LIMITS, 4'd0, 12'h000, 16'hffff, 16'h0000);
      send_beat(OP_READ_POS, 4'd0, 12'h000, 16'h0000, 16'h0000);
      send_beat(OP_SET_LIMITS, 4'd1, 12'hfff, 16'h0000, 16'hffff);
      send_beat(OP_READ_LIMITS, 4'd1, 12'h000, 16'h0000, 16'h0000);
      // Window of exactly twice the deadzone around the sum leaves a span of zero.
      s = int'(sum_q[0]);
      send_beat(OP_SET_LIMITS, 4'd0, 12'h000, 16'(clamp_int(s - DZ, 0, MAX_16)),
                16'(clamp_int(s + DZ, 0, MAX_16)));
      send_beat(OP_READ_POS, 4'd0, 12'h000, 16'h0000, 16'h0000);
      // Low above high stays inverted after widening, so reads give zero.
      s = int'(sum_q[0]);
      send_beat(OP_SET_LIMITS, 4'd0, 12'h000, 16'(clamp_int(s - DZ + 10, 0, MAX_16)),
                16'(clamp_int(s + DZ - 10, 0, MAX_16)));
      send_beat(OP_READ_POS, 4'd0, 12'h000, 16'h0000, 16'h0000);
      send_beat(OP_READ_LIMITS, 4'd0, 12'h000, 16'h0000, 16'h0000);
   endtask

   // A run of samples that hover around one level, with reads mixed in.
   task automatic sample_sweep(int level, int count);
      int v;
      repeat (count) begin
         v = clamp_int(level + int'($urandom_range(0, 128)) - 64, 0, SAMPLE_MASK);
         send_beat(OP_SAMPLE, 4'($urandom), 12'(v), 16'($urandom), 16'($urandom));
         if ($urandom_range(0, 3) == 0)
            send_beat(($urandom_range(0, 1) == 0) ? OP_READ_POS : OP_READ_LIMITS,
                      4'($urandom_range(0, N_DIALS - 1)), 12'($urandom), 16'($urandom),
                      16'($urandom));
      end
   endtask

   // Random calibration traffic: narrow windows, sweeps toward the rails, and noise.
   task automatic test_random_traffic(int unsigned quota, bit allow_idle);
      int unsigned stop_at;
      int          d;
      int          half;
      int          level;
      stop_at = beats_sent + quota;
      while (beats_sent < stop_at) begin
         send_idle_on = allow_idle && ($urandom_range(0, 4) != 0);
         rsp_stall_on = allow_idle && ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 2))
            0:       level = 0;
            1:       level = SAMPLE_MASK;
            default: level = $urandom_range(0, SAMPLE_MASK);
         endcase
         case ($urandom_range(0, 9))
            0, 1: begin
               repeat ($urandom_range(2, 8))
                  send_beat(sdr_op_type'($urandom_range(0, 3)), 4'($urandom),
                            12'($urandom), 16'($urandom), 16'($urandom));
            end
            2, 3, 4: begin
               // Pull a dial's window in close to its sum, then let the sum push it out.
               d    = $urandom_range(0, N_DIALS - 1);
               half = $urandom_range(0, 400);
               send_beat(OP_SET_LIMITS, 4'(d), 12'($urandom),
                         16'(clamp_int(int'(sum_q[d]) - half, 0, MAX_16)),
                         16'(clamp_int(int'(sum_q[d]) + half, 0, MAX_16)));
               sample_sweep(level, $urandom_range(4, 16));
            end
            default: sample_sweep(level, $urandom_range(8, 32));
         endcase
      end
   endtask

   // Long receiver hold while requests keep coming, then a full drain before more.
   task automatic test_backpressure();
      send_idle_on = 1'b0;
      hold_request = 1'b1;
      repeat (12)
         send_beat(sdr_op_type'($urandom_range(0, 3)), 4'($urandom_range(0, N_DIALS - 1)),
                   12'($urandom), 16'($urandom), 16'($urandom));
      wait_for_results();
      repeat (8)
         send_beat(sdr_op_type'($urandom_range(0, 3)), 4'($urandom_range(0, N_DIALS)),
                   12'($urandom), 16'($urandom), 16'($urandom));
      wait_for_results();
   endtask

   initial begin
      beats_sent        = 0;
      results_checked   = 0;
      mismatches        = 0;
      cycle_count       = 0;
      send_idle_on      = 1'b0;
      rsp_stall_on      = 1'b0;
      hold_request      = 1'b0;
      req_ch.valid      = 1'b0;
      req_ch.operation  = OP_SAMPLE;
      req_ch.dial       = '0;
      req_ch.sample     = '0;
      req_ch.limit_low  = '0;
      req_ch.limit_high = '0;
      reset_dial_state();

      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_sample_extremes();
      test_reads();
      test_bad_index();
      test_limit_corners();
      wait_for_results();
      test_random_traffic(540, 1'b1);
      wait_for_results();
      test_backpressure();
      test_random_traffic(60, 1'b0);

      wait_for_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Run covered %0d request beats: samples, reads, limit sets and bad indexes;",
               beats_sent);
      $display("%0d response beats checked, %0d field mismatches.", results_checked,
               mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
